[sv/ihr_pkg.sv]
// Shared types, constants and the header checksum for the IGMP host responder.
// No dependencies; every other file refers to it by scoped names.
package ihr_pkg;

  // Size of the joined group table
  localparam int unsigned MAX_GROUPS = 4;
  localparam int unsigned IDX_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_GROUPS + 1);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_FIRST = 3'd1;

  // Message constants
  localparam logic [7:0]  QUERY_TYPE  = 8'h11;
  localparam logic [7:0]  REPORT_TYPE = 8'h16;
  localparam logic [7:0]  LEAVE_TYPE  = 8'h17;
  localparam logic [31:0] ALL_ROUTERS = 32'hE000_0002;
  localparam logic [15:0] MIN_LENGTH  = 16'd8;
  localparam logic [3:0]  MCAST_NIB   = 4'hE;

  typedef enum logic [1:0] {
    CMD_RX    = 2'd0,
    CMD_JOIN  = 2'd1,
    CMD_LEAVE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_ONE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  interface_req;
    logic [15:0] msg_length;
    logic [7:0]  msg_type;
    logic [7:0]  msg_max_resp;
    logic [15:0] msg_checksum;
    logic [31:0] group;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_interface;
    logic [31:0] dest_addr;
    logic [7:0]  report_type;
    logic [31:0] report_group;
    logic [15:0] report_checksum;
    logic        status;
    logic        last;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic latch_in;    // capture the input item, reset the table index
    logic inc_idx;     // step to the next table entry
    logic load_one;    // load the join/leave result
    logic load_entry;  // load a report for the current table entry
    logic last;        // final result of this item
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic query_ok;    // length, checksum and type all good
    logic general;     // general query (group zero)
    logic idx_end;     // index has passed the valid entries
    logic qual;        // current entry gives a report
    logic more;        // a later entry gives a report (general query)
    logic slot_free;   // output register can take a result
  } sts_t;

  function automatic logic is_mcast(logic [31:0] a);
    return a[31:28] == MCAST_NIB;
  endfunction

  // Internet checksum of an 8-byte IGMP header, checksum word taken as zero
  function automatic logic [15:0] hdr_csum(logic [7:0] t, logic [7:0] m, logic [31:0] g);
    logic [17:0] s;
    logic [16:0] f;
    s = {2'd0, t, m} + {2'd0, g[31:16]} + {2'd0, g[15:0]};
    f = {1'b0, s[15:0]} + {15'd0, s[17:16]};
    return ~(f[15:0] + {15'd0, f[16]});
  endfunction

endpackage

[sv/ihr_ctrl.sv]
// Controller state machine of the IGMP host responder.
// Depends on ihr_pkg; drives the datapath through ihr_pkg::ctl_t.
module ihr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ihr_pkg::sts_t sts_i,
  output ihr_pkg::ctl_t ctl_o
);

  ihr_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ihr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    ctl_o      = '0;
    unique case (state_q)
      ihr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.latch_in = 1'b1;
          state_d        = ihr_pkg::ST_EVAL;
        end
      end
      ihr_pkg::ST_EVAL: begin
        unique case (sts_i.cmd)
          ihr_pkg::CMD_JOIN, ihr_pkg::CMD_LEAVE: state_d = ihr_pkg::ST_ONE;
          ihr_pkg::CMD_RX: begin
            state_d = sts_i.query_ok ? ihr_pkg::ST_SCAN : ihr_pkg::ST_IDLE;
          end
          default: state_d = ihr_pkg::ST_IDLE;
        endcase
      end
      ihr_pkg::ST_ONE: begin
        if (sts_i.slot_free) begin
          ctl_o.load_one = 1'b1;
          ctl_o.last     = 1'b1;
          state_d        = ihr_pkg::ST_IDLE;
        end
      end
      ihr_pkg::ST_SCAN: begin
        // walk the table, one entry per cycle, waiting when the output is full
        priority if (sts_i.idx_end) begin
          state_d = ihr_pkg::ST_IDLE;
        end else if (!sts_i.qual) begin
          ctl_o.inc_idx = 1'b1;
        end else if (sts_i.slot_free) begin
          ctl_o.load_entry = 1'b1;
          ctl_o.last       = !sts_i.general || !sts_i.more;
          if (ctl_o.last) begin
            state_d = ihr_pkg::ST_IDLE;
          end else begin
            ctl_o.inc_idx = 1'b1;
          end
        end
      end
      default: state_d = ihr_pkg::ST_IDLE;
    endcase
  end

endmodule

[sv/ihr_dp.sv]
// Datapath of the IGMP host responder: group table, input capture, table
// index, checks and the output register. Depends on ihr_pkg.
module ihr_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [ihr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ihr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  ihr_pkg::in_t                     in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output ihr_pkg::out_t                    out_data_o,
  input  ihr_pkg::ctl_t                    ctl_i,
  output ihr_pkg::sts_t                    sts_o
);

  logic [2:0]                    count_q;
  logic [31:0]                   tab_q [ihr_pkg::MAX_GROUPS];
  ihr_pkg::in_t                  in_q;
  logic [ihr_pkg::CNT_W-1:0]     idx_q;
  ihr_pkg::out_t                 out_q, out_d;
  logic                          out_valid_q;
  logic [ihr_pkg::CNT_W-1:0]     cnt;
  logic [31:0]                   entry;
  logic                          more;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < ihr_pkg::MAX_GROUPS; i++) begin
        tab_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      if (cfg_index_i == ihr_pkg::CFG_GROUP_COUNT) begin
        count_q <= cfg_data_i[2:0];
      end
      for (int i = 0; i < ihr_pkg::MAX_GROUPS; i++) begin
        if (cfg_index_i == ihr_pkg::CFG_GROUP_FIRST + ihr_pkg::CFG_IDX_W'(i)) begin
          tab_q[i] <= cfg_data_i;
        end
      end
    end
  end

  // Clamp the entry count to the table size
  assign cnt = ({29'd0, count_q} > 32'(ihr_pkg::MAX_GROUPS))
             ? ihr_pkg::CNT_W'(ihr_pkg::MAX_GROUPS)
             : ihr_pkg::CNT_W'(count_q);

  // Input capture and table index
  always_ff @(posedge clk_i) begin
    if (ctl_i.latch_in) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (ctl_i.latch_in) begin
      idx_q <= '0;
    end else if (ctl_i.inc_idx) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  assign entry = tab_q[idx_q[ihr_pkg::IDX_W-1:0]];

  // Any later valid entry that is multicast
  always_comb begin
    more = 1'b0;
    for (int j = 0; j < ihr_pkg::MAX_GROUPS; j++) begin
      if (ihr_pkg::CNT_W'(j) > idx_q && ihr_pkg::CNT_W'(j) < cnt
          && ihr_pkg::is_mcast(tab_q[j])) begin
        more = 1'b1;
      end
    end
  end

  // Status to the controller
  always_comb begin
    sts_o.cmd      = ihr_pkg::cmd_e'(in_q.command);
    sts_o.query_ok = (in_q.msg_length >= ihr_pkg::MIN_LENGTH)
                  && (ihr_pkg::hdr_csum(in_q.msg_type, in_q.msg_max_resp, in_q.group)
                      == in_q.msg_checksum)
                  && (in_q.msg_type == ihr_pkg::QUERY_TYPE);
    sts_o.general  = in_q.group == 32'd0;
    sts_o.idx_end  = idx_q >= cnt;
    sts_o.qual     = (idx_q < cnt)
                  && (sts_o.general ? ihr_pkg::is_mcast(entry) : (entry == in_q.group));
    sts_o.more     = more;
    sts_o.slot_free = !out_valid_q || out_ready_i;
  end

  // Result assembly
  always_comb begin
    out_d               = out_q;
    out_d.out_interface = in_q.interface_req;
    out_d.status        = 1'b0;
    out_d.last          = ctl_i.last;
    out_d.report_type   = ihr_pkg::REPORT_TYPE;
    if (ctl_i.load_entry) begin
      out_d.dest_addr    = entry;
      out_d.report_group = entry;
    end else if (!ihr_pkg::is_mcast(in_q.group)) begin
      // rejected join or leave
      out_d.dest_addr    = '0;
      out_d.report_type  = '0;
      out_d.report_group = '0;
      out_d.status       = 1'b1;
    end else if (ihr_pkg::cmd_e'(in_q.command) == ihr_pkg::CMD_LEAVE) begin
      out_d.dest_addr    = ihr_pkg::ALL_ROUTERS;
      out_d.report_type  = ihr_pkg::LEAVE_TYPE;
      out_d.report_group = in_q.group;
    end else begin
      out_d.dest_addr    = in_q.group;
      out_d.report_group = in_q.group;
    end
    out_d.report_checksum = out_d.status ? 16'd0
                          : ihr_pkg::hdr_csum(out_d.report_type, 8'd0, out_d.report_group);
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_one || ctl_i.load_entry) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.load_one || ctl_i.load_entry) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[sv/igmp_host_responder_top.sv]
// Flow: an input item is captured, then evaluated, then its first result is loaded
// into the output register once that register is free; a scan steps through the
// table entries and loads a report for each entry that qualifies.
// Throughput: one item at a time; a new item is taken only in the idle state;
// results leave at one per cycle unless the output stalls.
// Reset: asynchronous, active low; clears state, group count and table.
// Top level of the IGMP host responder; depends on ihr_pkg, ihr_ctrl and ihr_dp.
module igmp_host_responder_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ihr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ihr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  ihr_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output ihr_pkg::out_t                  out_data_o
);

  ihr_pkg::ctl_t ctl;
  ihr_pkg::sts_t sts;

  // configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  ihr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  ihr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .ctl_i       (ctl),
    .sts_o       (sts)
  );

endmodule

[sv/ihr_checker.sv]
// Port-level checks for the IGMP host responder, bound to the top level.
// Depends on ihr_pkg.
module ihr_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input ihr_pkg::out_t                  out_data_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // one item at a time: no transfer in the cycle after a transfer
  a_in_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while previous item in work");

  // a rejection is the only result of its item
  a_reject_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status |-> out_data_o.last)
    else $error("rejected result not marked last");

  // a report is sent to its own group
  a_report_dest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.report_type == ihr_pkg::REPORT_TYPE
    |-> out_data_o.dest_addr == out_data_o.report_group)
    else $error("report destination differs from group");

endmodule

bind igmp_host_responder_top ihr_checker u_ihr_checker (.*);
